>>> hdl/cpm_pkg.sv
// Shared constants and types of the cyclic polynomial multiplier.
package cpm_pkg;

  localparam int MAX_RING_SIZE = 1024;
  localparam int AW            = $clog2(MAX_RING_SIZE);
  localparam int NW            = AW + 1;

  localparam int COEFF_W   = 16;
  localparam int MOD_W     = 15;
  localparam int RING_W    = 11;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * COEFF_W;
  localparam int ACC_W     = PROD_W + AW;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LIFT = 2'd2;

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic             lift_en;
  } red_cfg_t;

endpackage

>>> hdl/cpm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cpm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cpm_reduce.sv
// Bit-serial modular reduction of the accumulated sum with optional centre lift.
module cpm_reduce (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [cpm_pkg::ACC_W-1:0]     acc,
  input  cpm_pkg::red_cfg_t                    cfg,
  output logic                                 done,
  output logic signed [cpm_pkg::COEFF_W-1:0]   value
);

  localparam int CW = $clog2(cpm_pkg::ACC_W + 1);

  typedef enum logic [2:0] {
    R_IDLE = 3'b001,
    R_STEP = 3'b010,
    R_FIN  = 3'b100
  } rstate_t;

  typedef logic [CW-1:0] cnt_t;

  rstate_t                      state_r, state_nxt;
  logic [cpm_pkg::ACC_W-1:0]    mag_r, mag_nxt;
  logic [cpm_pkg::MOD_W:0]      rem_r, rem_nxt;
  logic [cpm_pkg::MOD_W-1:0]    q_r, q_nxt;
  logic                         neg_r, neg_nxt;
  logic                         lift_r, lift_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         done_r, done_nxt;
  logic [cpm_pkg::COEFF_W-1:0]  value_r, value_nxt;

  logic [cpm_pkg::MOD_W:0]      trial;
  logic [cpm_pkg::MOD_W-1:0]    rfix;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    neg_nxt   = neg_r;
    lift_nxt  = lift_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    value_nxt = value_r;
    trial     = {rem_r[cpm_pkg::MOD_W-1:0], mag_r[cpm_pkg::ACC_W-1]};
    rfix      = rem_r[cpm_pkg::MOD_W-1:0];
    case (state_r)
      R_IDLE: begin
        if (start) begin
          neg_nxt   = acc[cpm_pkg::ACC_W-1];
          mag_nxt   = acc[cpm_pkg::ACC_W-1] ? -acc : acc;
          q_nxt     = (cfg.modulus == '0) ? cpm_pkg::MOD_W'(1) : cfg.modulus;
          lift_nxt  = cfg.lift_en;
          rem_nxt   = '0;
          cnt_nxt   = cnt_t'(cpm_pkg::ACC_W);
          state_nxt = R_STEP;
        end
      end
      R_STEP: begin
        rem_nxt = (trial >= {1'b0, q_r}) ? trial - {1'b0, q_r} : trial;
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r - cnt_t'(1);
        if (cnt_r == cnt_t'(1)) begin
          state_nxt = R_FIN;
        end
      end
      R_FIN: begin
        if (neg_r && (rfix != '0)) begin
          rfix = q_r - rfix;
        end
        if (lift_r && (rfix > (q_r >> 1))) begin
          value_nxt = {1'b0, rfix} - {1'b0, q_r};
        end else begin
          value_nxt = {1'b0, rfix};
        end
        done_nxt  = 1'b1;
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    neg_r   <= neg_nxt;
    lift_r  <= lift_nxt;
    value_r <= value_nxt;
  end

  assign done  = done_r;
  assign value = value_r;

endmodule

>>> hdl/cyclic_poly_multiply_mod_q.sv
// Top level of the cyclic polynomial multiplier over Z_q[x]/(x^N-1).
//
// A load writes one coefficient of each operand at the same index. The load of
// index N-1 starts the convolution, during which busy stays high and no load or
// read is accepted: each product coefficient is accumulated from N products
// through the single shared MAC, whose pipeline then drains before a bit-serial
// reduction of the sum yields the stored residue. A read passes through the
// product RAM's registered read and the output registers; its result appears on
// the out_ ports for one cycle, marked by out_valid, and must be taken then.
module cyclic_poly_multiply_mod_q (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_req_type,
  input  logic [cpm_pkg::AW-1:0]                 in_coeff_index,
  input  logic signed [cpm_pkg::COEFF_W-1:0]     in_a_coeff,
  input  logic signed [cpm_pkg::COEFF_W-1:0]     in_b_coeff,
  output logic                                   out_valid,
  output logic signed [cpm_pkg::COEFF_W-1:0]     out_product_coeff,
  output logic [cpm_pkg::AW-1:0]                 out_result_index,
  input  logic                                   cfg_we,
  input  logic [cpm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [cpm_pkg::CFG_W-1:0]              cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_DIV   = 6'b001000,
    S_RD    = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  typedef logic [cpm_pkg::NW-1:0]           n_t;
  typedef logic [cpm_pkg::AW-1:0]           idx_t;
  typedef logic signed [cpm_pkg::ACC_W-1:0] acc_t;

  state_t                             state_r, state_nxt;
  logic [cpm_pkg::MOD_W-1:0]          modulus_r;
  logic [cpm_pkg::RING_W-1:0]         ring_size_r;
  logic                               lift_en_r;

  logic [cpm_pkg::AW-1:0]             i_r, i_nxt;
  logic [cpm_pkg::AW-1:0]             j_r, j_nxt;
  logic [cpm_pkg::AW-1:0]             k_r, k_nxt;
  logic                               v1_r, v1_nxt;
  logic                               v2_r, v2_nxt;
  logic signed [cpm_pkg::PROD_W-1:0]  prod_r;
  logic signed [cpm_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [cpm_pkg::AW-1:0]             idx_r, idx_nxt;
  logic                               inrange_r, inrange_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic [cpm_pkg::COEFF_W-1:0]        out_coeff_r, out_coeff_nxt;
  logic [cpm_pkg::AW-1:0]             out_index_r, out_index_nxt;

  logic [cpm_pkg::NW-1:0]             n_eff;
  logic [cpm_pkg::AW-1:0]             n_last;
  logic                               accept;
  logic                               in_range;
  logic                               load_ok;
  logic                               mac_issue;
  logic                               red_start;
  logic                               red_done;
  logic signed [cpm_pkg::COEFF_W-1:0] red_value;
  cpm_pkg::red_cfg_t                  red_cfg;

  logic [cpm_pkg::COEFF_W-1:0]        a_rd;
  logic [cpm_pkg::COEFF_W-1:0]        b_rd;
  logic [cpm_pkg::COEFF_W-1:0]        p_rd;
  logic                               p_we;
  logic                               p_re;

  always_comb begin
    if (ring_size_r == '0) begin
      n_eff = n_t'(1);
    end else if (int'(ring_size_r) > cpm_pkg::MAX_RING_SIZE) begin
      n_eff = n_t'(cpm_pkg::MAX_RING_SIZE);
    end else begin
      n_eff = n_t'(ring_size_r);
    end
  end

  assign n_last    = idx_t'(n_eff - n_t'(1));
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_range  = ({1'b0, in_coeff_index} < n_eff);
  assign load_ok   = accept && (in_req_type == cpm_pkg::REQ_LOAD) && in_range;
  assign mac_issue = (state_r == S_MAC);
  assign red_start = (state_r == S_DRAIN) && !v1_r && !v2_r;
  assign p_we      = (state_r == S_DIV) && red_done;
  assign p_re      = accept && (in_req_type == cpm_pkg::REQ_READ);
  assign red_cfg   = '{modulus: modulus_r, lift_en: lift_en_r};

  cpm_ram #(.WIDTH(cpm_pkg::COEFF_W), .DEPTH(cpm_pkg::MAX_RING_SIZE)) u_ram_a (
    .clk   (clk),
    .we    (load_ok),
    .waddr (in_coeff_index),
    .wdata (in_a_coeff),
    .re    (mac_issue),
    .raddr (i_r),
    .rdata (a_rd)
  );

  cpm_ram #(.WIDTH(cpm_pkg::COEFF_W), .DEPTH(cpm_pkg::MAX_RING_SIZE)) u_ram_b (
    .clk   (clk),
    .we    (load_ok),
    .waddr (in_coeff_index),
    .wdata (in_b_coeff),
    .re    (mac_issue),
    .raddr (j_r),
    .rdata (b_rd)
  );

  cpm_ram #(.WIDTH(cpm_pkg::COEFF_W), .DEPTH(cpm_pkg::MAX_RING_SIZE)) u_ram_p (
    .clk   (clk),
    .we    (p_we),
    .waddr (k_r),
    .wdata (red_value),
    .re    (p_re),
    .raddr (in_coeff_index),
    .rdata (p_rd)
  );

  cpm_reduce u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .acc   (acc_r),
    .cfg   (red_cfg),
    .done  (red_done),
    .value (red_value)
  );

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    inrange_nxt   = inrange_r;
    out_valid_nxt = 1'b0;
    out_coeff_nxt = out_coeff_r;
    out_index_nxt = out_index_r;
    v1_nxt        = mac_issue;
    v2_nxt        = v1_r;
    acc_nxt       = v2_r ? acc_r + acc_t'(prod_r) : acc_r;
    case (state_r)
      S_IDLE: begin
        if (p_re) begin
          idx_nxt     = in_coeff_index;
          inrange_nxt = in_range;
          state_nxt   = S_RD;
        end else if (load_ok && (in_coeff_index == n_last)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        i_nxt = i_r + idx_t'(1);
        j_nxt = (j_r == '0) ? n_last : j_r - idx_t'(1);
        if (i_r == n_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (red_start) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (red_done) begin
          if (k_r == n_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + idx_t'(1);
            j_nxt     = k_r + idx_t'(1);
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_RD: begin
        out_valid_nxt = 1'b1;
        out_coeff_nxt = inrange_r ? p_rd : '0;
        out_index_nxt = idx_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      modulus_r   <= cpm_pkg::MOD_W'(2048);
      ring_size_r <= cpm_pkg::RING_W'(509);
      lift_en_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cpm_pkg::CFG_MODULUS:     modulus_r   <= cfg_data[cpm_pkg::MOD_W-1:0];
          cpm_pkg::CFG_RING_SIZE:   ring_size_r <= cfg_data[cpm_pkg::RING_W-1:0];
          cpm_pkg::CFG_CENTER_LIFT: lift_en_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= $signed(a_rd) * $signed(b_rd);
    acc_r       <= acc_nxt;
    idx_r       <= idx_nxt;
    inrange_r   <= inrange_nxt;
    out_coeff_r <= out_coeff_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_product_coeff = out_coeff_r;
  assign out_result_index  = out_index_r;

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_RD))
    else $error("result strobe without a read transfer");

  a_read_enters_rd: assert property (@(posedge clk) disable iff (!rst_n)
    p_re |=> (state_r == S_RD))
    else $error("read transfer did not enter read state");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("MAC pipeline valid out of order");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && red_done |=> (state_r == S_MAC) || (state_r == S_IDLE))
    else $error("bad transition after reduction");

  a_no_mac_while_reducing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> !v1_r && !v2_r)
    else $error("MAC pipeline active during reduction");

endmodule
